>>> hdl/u8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int ST_W   = 2;
    localparam int REM_W  = 2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT = 2'd2;

    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_length;
        logic [ST_W-1:0]  status;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_ready  i_data_byte[7:0]
// result   out        o_valid / i_ready  o_codepoint[20:0], o_seq_length[2:0], o_status[1:0]
//
// One byte per cycle sustained while the result side is not stalled; a result passes the
// input register, then the result register, after the edge that accepts its last byte.
// Valid lead bytes of multi-byte sequences and middle continuation bytes produce no result beat.
// Reset is synchronous, active low; it empties both registers and the decode state.
// A stalled result stops the input register; o_ready stays high while a beat can advance.

module utf8_byte_stream_decoder (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [u8d_pkg::BYTE_W-1:0] i_data_byte,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [u8d_pkg::CP_W-1:0]        o_codepoint,
    output logic [u8d_pkg::LEN_W-1:0]       o_seq_length,
    output logic [u8d_pkg::ST_W-1:0]        o_status
);
    import u8d_pkg::*;

    logic              w_out_free;
    logic              w_advance;
    logic [BYTE_W-1:0] w_byte;
    logic              w_emit;
    t_result           w_result;

    u8d_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_out_free  (w_out_free),
        .o_advance   (w_advance),
        .o_byte      (w_byte)
    );

    u8d_decode u_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (w_byte),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    u8d_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_advance && w_emit),
        .i_result     (w_result),
        .o_free       (w_out_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_codepoint  (o_codepoint),
        .o_seq_length (o_seq_length),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire

>>> hdl/u8d_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [u8d_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                       i_out_free,
    output logic                            o_advance,
    output logic [u8d_pkg::BYTE_W-1:0]      o_byte
);
    import u8d_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // beat in the register is consumed when the result side can take it
    assign o_advance = r_valid && i_out_free;
    assign o_ready   = !r_valid || i_out_free;
    assign o_byte    = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_free) |=> (r_valid && $stable(r_byte)))
        else $error("held input beat lost or changed");

endmodule

`default_nettype wire

>>> hdl/u8d_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire logic [u8d_pkg::BYTE_W-1:0] i_byte,
    output logic                            o_emit,
    output u8d_pkg::t_result                o_result
);
    import u8d_pkg::*;

    logic [REM_W-1:0] r_rem,   n_rem;
    logic [LEN_W-1:0] r_total, n_total;
    logic [CP_W-1:0]  r_acc,   n_acc;

    logic [CP_W-1:0]  w_cont_bits;
    logic [CP_W-1:0]  w_acc_cont;
    logic [REM_W-1:0] w_rem_dec;

    always_comb begin
        case (r_rem)
            2'd1:    w_cont_bits = {15'd0, i_byte[5:0]};
            2'd2:    w_cont_bits = {9'd0, i_byte[5:0], 6'd0};
            2'd3:    w_cont_bits = {3'd0, i_byte[5:0], 12'd0};
            default: w_cont_bits = '0;
        endcase
    end

    assign w_acc_cont = r_acc | w_cont_bits;
    assign w_rem_dec  = r_rem - 2'd1;

    always_comb begin
        n_rem    = r_rem;
        n_total  = r_total;
        n_acc    = r_acc;
        o_emit   = 1'b0;
        o_result = '0;
        if (r_rem == '0) begin
            if (!i_byte[7]) begin
                o_emit              = 1'b1;
                o_result.codepoint  = {13'd0, i_byte};
                o_result.seq_length = 3'd1;
                o_result.status     = ST_OK;
            end else if (!i_byte[6]) begin
                o_emit          = 1'b1;
                o_result.status = ST_BAD_LEAD;
            end else if (!i_byte[5]) begin
                n_acc   = {10'd0, i_byte[4:0], 6'd0};
                n_total = 3'd2;
                n_rem   = 2'd1;
            end else if (!i_byte[4]) begin
                n_acc   = {5'd0, i_byte[3:0], 12'd0};
                n_total = 3'd3;
                n_rem   = 2'd2;
            end else if (!i_byte[3]) begin
                n_acc   = {i_byte[2:0], 18'd0};
                n_total = 3'd4;
                n_rem   = 2'd3;
            end else begin
                o_emit          = 1'b1;
                o_result.status = ST_BAD_LEAD;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            n_rem           = '0;
            n_total         = '0;
            n_acc           = '0;
            o_emit          = 1'b1;
            o_result.status = ST_BAD_CONT;
        end else if (w_rem_dec == '0) begin
            o_emit              = 1'b1;
            o_result.codepoint  = w_acc_cont;
            o_result.seq_length = r_total;
            o_result.status     = ST_OK;
            n_rem               = '0;
            n_total             = '0;
            n_acc               = '0;
        end else begin
            n_acc = w_acc_cont;
            n_rem = w_rem_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_total <= '0;
            r_acc   <= '0;
        end else if (i_advance) begin
            r_rem   <= n_rem;
            r_total <= n_total;
            r_acc   <= n_acc;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem == '0) |-> (r_total == '0 && r_acc == '0))
        else $error("state not cleared while awaiting lead byte");

    a_total_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> ({1'b0, r_rem} < r_total && r_total <= 3'd4))
        else $error("sequence length inconsistent with bytes remaining");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.status != ST_OK)
            |-> (o_result.codepoint == '0 && o_result.seq_length == '0))
        else $error("error result carries payload");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_result.status == ST_OK) |-> (o_result.seq_length != '0))
        else $error("ok result with zero length");

endmodule

`default_nettype wire

>>> hdl/u8d_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_stage (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire u8d_pkg::t_result        i_result,
    output logic                         o_free,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [u8d_pkg::CP_W-1:0]     o_codepoint,
    output logic [u8d_pkg::LEN_W-1:0]    o_seq_length,
    output logic [u8d_pkg::ST_W-1:0]     o_status
);
    import u8d_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free       = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_codepoint  = r_result.codepoint;
    assign o_seq_length = r_result.seq_length;
    assign o_status     = r_result.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_result)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
